### design/wovc_pkg.sv
// Shared types, constants and the case-fold function for the word overlap counter.
`timescale 1ns / 1ps

package wovc_pkg;

    localparam int REF_WORDS      = 1024;
    localparam int MAX_WORD_CHARS = 8;

    localparam int CELLS      = 4;
    localparam int CELL_W     = $clog2(CELLS);
    localparam int BANK_DEPTH = (REF_WORDS + CELLS - 1) / CELLS;
    localparam int BANK_AW    = (BANK_DEPTH > 1) ? $clog2(BANK_DEPTH) : 1;
    localparam int REFCNT_W   = $clog2(REF_WORDS + 1);

    localparam int WORD_W = 64;
    localparam int CNT_W  = 24;
    localparam int PCT_W  = 7;
    localparam int NUM_W  = CNT_W + PCT_W;

    localparam logic [CNT_W-1:0] CNT_MAX  = {CNT_W{1'b1}};
    localparam logic [7:0]       CHAR_A   = 8'h41;
    localparam logic [7:0]       CHAR_Z   = 8'h5A;
    localparam logic [7:0]       CASE_OFS = 8'd32;
    localparam logic [PCT_W-1:0] PCT_MAX  = 7'd100;

    typedef logic [WORD_W-1:0]  word_t;
    typedef logic [BANK_AW-1:0] bank_addr_t;

    typedef enum logic [1:0] {
        MODE_REF    = 2'd0,
        MODE_SRC    = 2'd1,
        MODE_REPORT = 2'd2,
        MODE_CLEAR  = 2'd3
    } mode_t;

    // search beat moving along the cell row
    typedef struct packed {
        logic       valid;
        logic       last;
        logic       hit;
        bank_addr_t addr;
        word_t      key;
    } tok_t;

    function automatic word_t fold_word(input word_t w);
        word_t      r;
        logic [7:0] b;
        r = '0;
        for (int i = 0; i < 8; i++) begin
            b = w[8*i +: 8];
            if (i >= MAX_WORD_CHARS)
                b = 8'd0;
            else if (b >= CHAR_A && b <= CHAR_Z)
                b = b + CASE_OFS;
            r[8*i +: 8] = b;
        end
        return r;
    endfunction

endpackage

### design/word_overlap_counter_top.sv
// Top level of the word overlap counter: command decode, cell row and result registers.
`timescale 1ns / 1ps

// Takes one command per start beat while busy is low; its result shows for exactly one
// cycle with done high and cannot be held off. Store, clear, a check against an empty
// store, and a report with no source words finish without going busy, and the next
// command may be taken in the cycle their result shows. A check walks the reference
// store, spread over four cell banks read one row per cycle, then waits for the last row
// to pass the two-stage pass through each cell. A report with source words runs the
// bit-serial divider. Words are case folded before store and compare.

module word_overlap_counter_top (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [1:0]  mode,
    input  logic [63:0] word_chars,
    output logic        done,
    output logic        found,
    output logic        table_full,
    output logic [23:0] source_words,
    output logic [23:0] matched_words,
    output logic [6:0]  percent,
    output logic        no_source
);
    import wovc_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_DRAIN,
        S_DIV
    } state_t;

    state_t              state_reg;
    logic [REFCNT_W-1:0] ref_count_reg;
    logic [CNT_W-1:0]    src_reg;
    logic [CNT_W-1:0]    match_reg;
    word_t               key_reg;
    bank_addr_t          iss_reg;
    bank_addr_t          last_row_reg;
    logic                hit_acc_reg;
    logic                done_reg;
    logic                found_reg;
    logic                full_reg;
    logic [PCT_W-1:0]    pct_reg;
    logic                nosrc_reg;

    logic                accept;
    word_t               folded;
    logic                store_full;
    logic [REFCNT_W-1:0] count_m1;
    logic [CNT_W-1:0]    src_next;
    logic                found_now;
    logic                div_start;
    logic                div_done;
    logic [PCT_W-1:0]    div_q;
    logic [NUM_W-1:0]    div_num;
    logic                cell_clr;
    logic [CELLS-1:0]    cell_we;
    tok_t                chain [CELLS+1];

    assign accept     = start && (state_reg == S_IDLE);
    assign folded     = fold_word(word_chars);
    assign store_full = (ref_count_reg == REFCNT_W'(REF_WORDS));
    assign count_m1   = ref_count_reg - 1'b1;
    assign src_next   = (src_reg == CNT_MAX) ? src_reg : src_reg + 1'b1;
    assign found_now  = hit_acc_reg | (chain[CELLS].valid & chain[CELLS].hit);
    assign cell_clr   = accept && (mode == MODE_CLEAR);
    assign div_start  = accept && (mode == MODE_REPORT) && (src_reg != '0);
    assign div_num    = NUM_W'(match_reg) * NUM_W'(PCT_MAX);

    always_comb
    begin
        for (int i = 0; i < CELLS; i++)
            cell_we[i] = accept && (mode == MODE_REF) && !store_full
                         && (ref_count_reg[CELL_W-1:0] == CELL_W'(i));
    end

    // row sweep enters at the head of the cell row
    assign chain[0] = '{valid: (state_reg == S_SCAN),
                        last:  (iss_reg == last_row_reg),
                        hit:   1'b0,
                        addr:  iss_reg,
                        key:   key_reg};

    for (genvar g = 0; g < CELLS; g++)
    begin : g_cell
        wovc_cell u_cell (
            .clk     (clk),
            .rst_n   (rst_n),
            .clr     (cell_clr),
            .wr_en   (cell_we[g]),
            .wr_addr (ref_count_reg[CELL_W +: BANK_AW]),
            .wr_data (folded),
            .tok_in  (chain[g]),
            .tok_out (chain[g+1])
        );
    end

    wovc_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (div_num),
        .den   (src_reg),
        .done  (div_done),
        .quot  (div_q)
    );

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            ref_count_reg <= '0;
            src_reg       <= '0;
            match_reg     <= '0;
            key_reg       <= '0;
            iss_reg       <= '0;
            last_row_reg  <= '0;
            hit_acc_reg   <= 1'b0;
            done_reg      <= 1'b0;
            found_reg     <= 1'b0;
            full_reg      <= 1'b0;
            pct_reg       <= '0;
            nosrc_reg     <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            case (state_reg)
                S_IDLE:
                begin
                    if (accept)
                    begin
                        found_reg <= 1'b0;
                        full_reg  <= 1'b0;
                        pct_reg   <= '0;
                        nosrc_reg <= 1'b0;
                        case (mode)
                            MODE_REF:
                            begin
                                done_reg <= 1'b1;
                                if (store_full)
                                    full_reg <= 1'b1;
                                else
                                    ref_count_reg <= ref_count_reg + 1'b1;
                            end
                            MODE_SRC:
                            begin
                                if (ref_count_reg == '0)
                                begin
                                    done_reg <= 1'b1;
                                    src_reg  <= src_next;
                                end
                                else
                                begin
                                    state_reg    <= S_SCAN;
                                    key_reg      <= folded;
                                    iss_reg      <= '0;
                                    last_row_reg <= count_m1[CELL_W +: BANK_AW];
                                    hit_acc_reg  <= 1'b0;
                                end
                            end
                            MODE_REPORT:
                            begin
                                if (src_reg == '0)
                                begin
                                    done_reg  <= 1'b1;
                                    nosrc_reg <= 1'b1;
                                end
                                else
                                    state_reg <= S_DIV;
                            end
                            default:
                            begin
                                done_reg      <= 1'b1;
                                ref_count_reg <= '0;
                                src_reg       <= '0;
                                match_reg     <= '0;
                            end
                        endcase
                    end
                end
                S_SCAN:
                begin
                    hit_acc_reg <= found_now;
                    if (iss_reg == last_row_reg)
                        state_reg <= S_DRAIN;
                    else
                        iss_reg <= iss_reg + 1'b1;
                end
                S_DRAIN:
                begin
                    hit_acc_reg <= found_now;
                    if (chain[CELLS].valid && chain[CELLS].last)
                    begin
                        state_reg <= S_IDLE;
                        done_reg  <= 1'b1;
                        found_reg <= found_now;
                        src_reg   <= src_next;
                        if (found_now && (match_reg < src_next))
                            match_reg <= match_reg + 1'b1;
                    end
                end
                S_DIV:
                begin
                    if (div_done)
                    begin
                        state_reg <= S_IDLE;
                        done_reg  <= 1'b1;
                        pct_reg   <= (div_q > PCT_MAX) ? PCT_MAX : div_q;
                    end
                end
                default:
                    state_reg <= S_IDLE;
            endcase
        end
    end

    assign busy          = (state_reg != S_IDLE);
    assign done          = done_reg;
    assign found         = found_reg;
    assign table_full    = full_reg;
    assign source_words  = src_reg;
    assign matched_words = match_reg;
    assign percent       = pct_reg;
    assign no_source     = nosrc_reg;

    a_match_le_src: assert property (@(posedge clk) disable iff (!rst_n)
        matched_words <= source_words)
        else $error("match count exceeds source count");

    a_pct_range: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> percent <= PCT_MAX)
        else $error("percentage above 100");

    a_idle_chain: assert property (@(posedge clk) disable iff (!rst_n)
        !busy |-> !chain[CELLS].valid)
        else $error("search beat leaves the cell row while idle");

    a_clear: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && mode == MODE_CLEAR) |=>
            (done && source_words == '0 && matched_words == '0))
        else $error("clear did not report zero counters");

endmodule

### design/wovc_cell.sv
// One search cell: a bank of reference words, its fill count and a two-stage compare.
`timescale 1ns / 1ps

module wovc_cell (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              clr,
    input  logic              wr_en,
    input  wovc_pkg::bank_addr_t wr_addr,
    input  wovc_pkg::word_t   wr_data,
    input  wovc_pkg::tok_t    tok_in,
    output wovc_pkg::tok_t    tok_out
);
    import wovc_pkg::*;

    word_t              mem [BANK_DEPTH];
    word_t              rdata_reg;
    logic [BANK_AW:0]   fill_reg;
    logic               in_range_reg;
    tok_t               tok_a_reg;
    tok_t               tok_b_reg;
    tok_t               tok_b_next;

    always_ff @(posedge clk) begin
        if (wr_en)
            mem[wr_addr] <= wr_data;
        rdata_reg <= mem[tok_in.addr];
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n)
        begin
            fill_reg     <= '0;
            in_range_reg <= 1'b0;
            tok_a_reg    <= '0;
            tok_b_reg    <= '0;
        end
        else
        begin
            if (clr)
                fill_reg <= '0;
            else if (wr_en)
                fill_reg <= fill_reg + 1'b1;
            in_range_reg <= ({1'b0, tok_in.addr} < fill_reg);
            tok_a_reg    <= tok_in;
            tok_b_reg    <= tok_b_next;
        end
    end

    always_comb
    begin
        tok_b_next     = tok_a_reg;
        tok_b_next.hit = tok_a_reg.hit
                         | (tok_a_reg.valid & in_range_reg & (rdata_reg == tok_a_reg.key));
    end

    assign tok_out = tok_b_reg;

endmodule

### design/wovc_div.sv
// Restoring divider for the percentage, one quotient bit per cycle.
`timescale 1ns / 1ps

module wovc_div (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    input  logic [wovc_pkg::NUM_W-1:0]   num,
    input  logic [wovc_pkg::CNT_W-1:0]   den,
    output logic                         done,
    output logic [wovc_pkg::PCT_W-1:0]   quot
);
    import wovc_pkg::*;

    localparam int STEP_W = $clog2(PCT_W);

    logic [NUM_W-1:0]  rem_reg;
    logic [NUM_W-1:0]  dsh_reg;
    logic [PCT_W-1:0]  q_reg;
    logic [STEP_W-1:0] step_reg;
    logic              run_reg;
    logic              done_reg;
    logic              ge;

    assign ge = (rem_reg >= dsh_reg);

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                run_reg  <= 1'b1;
                step_reg <= STEP_W'(PCT_W - 1);
            end
            else if (run_reg)
            begin
                if (step_reg == '0)
                begin
                    run_reg  <= 1'b0;
                    done_reg <= 1'b1;
                end
                else
                    step_reg <= step_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge clk) begin
        if (start)
        begin
            rem_reg <= num;
            dsh_reg <= {1'b0, den, {(PCT_W-1){1'b0}}};
            q_reg   <= '0;
        end
        else if (run_reg)
        begin
            if (ge)
                rem_reg <= rem_reg - dsh_reg;
            q_reg   <= {q_reg[PCT_W-2:0], ge};
            dsh_reg <= dsh_reg >> 1;
        end
    end

    assign done = done_reg;
    assign quot = q_reg;

endmodule

### tb/sv/word_overlap_counter_top_tb.sv
// Self-checking testbench for the word overlap counter top level.
`timescale 1ns / 1ps

module word_overlap_counter_top_tb;

    import wovc_pkg::*;

    typedef struct {
        mode_t       op;
        logic [63:0] chars;
    } word_cmd_t;

    typedef struct {
        logic        found;
        logic        full;
        logic [23:0] src;
        logic [23:0] hits;
        logic [6:0]  pct;
        logic        nosrc;
    } overlap_result_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        start = 1'b0;
    logic        busy;
    logic [1:0]  mode = MODE_REF;
    logic [63:0] word_chars = 64'd0;
    logic        done;
    logic        found;
    logic        table_full;
    logic [23:0] source_words;
    logic [23:0] matched_words;
    logic [6:0]  percent;
    logic        no_source;

    word_cmd_t       word_cmds[$];
    overlap_result_t due_results[$];
    int              mismatches = 0;

    // predictor state: folded reference words and running totals
    logic [63:0] stored_words[REF_WORDS];
    int          stored_fill = 0;
    logic [23:0] src_total = '0;
    logic [23:0] hit_total = '0;

    // idle burst control
    int gap_left = 0;
    int stretch_left = 0;
    bit calm = 1'b0;

    always #1 clk = ~clk;

    word_overlap_counter_top u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (start),
        .busy          (busy),
        .mode          (mode),
        .word_chars    (word_chars),
        .done          (done),
        .found         (found),
        .table_full    (table_full),
        .source_words  (source_words),
        .matched_words (matched_words),
        .percent       (percent),
        .no_source     (no_source)
    );

    function automatic logic [63:0] lower_word(input logic [63:0] w);
        logic [63:0] r;
        logic [7:0]  c;
        for (int i = 0; i < 8; i++)
        begin
            c = w[8*i +: 8];
            if (c >= CHAR_A && c <= CHAR_Z)
                c = c + 8'd32;
            r[8*i +: 8] = c;
        end
        return r;
    endfunction

    function automatic overlap_result_t predict_overlap(input mode_t op, input logic [63:0] w);
        overlap_result_t r;
        logic [63:0]     key;
        logic [63:0]     ratio;
        r = '{found: 1'b0, full: 1'b0, src: '0, hits: '0, pct: '0, nosrc: 1'b0};
        key = lower_word(w);
        case (op)
            MODE_REF:
            begin
                if (stored_fill < REF_WORDS)
                begin
                    stored_words[stored_fill] = key;
                    stored_fill++;
                end
                else
                    r.full = 1'b1;
            end
            MODE_SRC:
            begin
                for (int k = 0; k < stored_fill; k++)
                    if (stored_words[k] == key)
                        r.found = 1'b1;
                if (src_total != CNT_MAX)
                    src_total++;
                if (r.found && hit_total < src_total)
                    hit_total++;
            end
            MODE_REPORT:
            begin
                if (src_total == 0)
                    r.nosrc = 1'b1;
                else
                begin
                    ratio = (64'(hit_total) * 64'd100) / 64'(src_total);
                    r.pct = (ratio > 64'd100) ? PCT_MAX : ratio[6:0];
                end
            end
            default:
            begin
                stored_fill = 0;
                src_total = '0;
                hit_total = '0;
            end
        endcase
        r.src = src_total;
        r.hits = hit_total;
        return r;
    endfunction

    task automatic check_field(input string name, input logic [23:0] want,
                               input logic [23:0] got);
        if (got !== want)
        begin
            $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
            mismatches++;
        end
    endtask

    task automatic queue_cmd(input mode_t op, input logic [63:0] chars);
        word_cmd_t c;
        c.op = op;
        c.chars = chars;
        word_cmds.push_back(c);
    endtask

    // first character lands in the low byte
    function automatic logic [63:0] pack_text(input string s);
        logic [63:0] w;
        w = '0;
        for (int i = 0; i < s.len() && i < 8; i++)
            w[8*i +: 8] = s[i];
        return w;
    endfunction

    function automatic logic [63:0] random_text();
        logic [63:0] w;
        logic [7:0]  c;
        int          n;
        w = '0;
        n = $urandom_range(1, 8);
        for (int i = 0; i < n; i++)
        begin
            if ($urandom_range(0, 7) == 0)
                c = 8'($urandom_range(8'h21, 8'h7E));
            else
            begin
                c = 8'h61 + 8'($urandom_range(0, 25));
                if ($urandom_range(0, 1) == 1)
                    c = c - 8'd32;
            end
            w[8*i +: 8] = c;
        end
        return w;
    endfunction

    function automatic logic [63:0] recase(input logic [63:0] w);
        logic [7:0] c;
        for (int i = 0; i < 8; i++)
        begin
            c = w[8*i +: 8];
            if (((c >= 8'h41 && c <= 8'h5A) || (c >= 8'h61 && c <= 8'h7A))
                && $urandom_range(0, 1) == 1)
                w[8*i +: 8] = c ^ 8'h20;
        end
        return w;
    endfunction

    // driver: holds a command until the accepting edge, then moves to the next
    always @(posedge clk)
    begin : driver
        bit accepted;
        if (rst_n)
        begin
            if (stretch_left == 0)
            begin
                stretch_left = $urandom_range(20, 120);
                calm = ($urandom_range(0, 2) == 0);
            end
            else
                stretch_left--;
            accepted = start && !busy;
            if (accepted)
                void'(word_cmds.pop_front());
            if (!start || accepted)
            begin
                if (gap_left == 0 && !calm && word_cmds.size() > 40
                    && $urandom_range(0, 5) == 0)
                    gap_left = $urandom_range(1, 16);
                if (gap_left > 0)
                begin
                    gap_left--;
                    start <= 1'b0;
                end
                else if (word_cmds.size() > 0)
                begin
                    start <= 1'b1;
                    mode <= word_cmds[0].op;
                    word_chars <= word_cmds[0].chars;
                end
                else
                    start <= 1'b0;
            end
        end
    end

    // monitor: predicts at each accepted beat, checks each done beat
    always @(posedge clk)
    begin : monitor
        overlap_result_t want;
        if (rst_n)
        begin
            if (start && !busy)
                due_results.push_back(predict_overlap(mode_t'(mode), word_chars));
            if (done)
            begin
                if (due_results.size() == 0)
                begin
                    $display("%0t: result with none expected, expected nothing, got src %0d",
                             $time, source_words);
                    mismatches++;
                end
                else
                begin
                    want = due_results.pop_front();
                    check_field("found", want.found, found);
                    check_field("table_full", want.full, table_full);
                    check_field("source_words", want.src, source_words);
                    check_field("matched_words", want.hits, matched_words);
                    check_field("percent", want.pct, percent);
                    check_field("no_source", want.nosrc, no_source);
                end
            end
        end
    end

    initial
    begin
        logic [63:0] refs_now[$];
        logic [63:0] w;
        int          queued;
        int          nref;
        int          nsrc;

        // directed: empty totals, folding edges, embedded zero, duplicates, clear, 100 %
        queue_cmd(MODE_REPORT, 64'd0);
        queue_cmd(MODE_SRC, pack_text("cat"));
        queue_cmd(MODE_REPORT, {64{1'b1}});
        queue_cmd(MODE_CLEAR, 64'd0);
        queue_cmd(MODE_REF, 64'd0);
        queue_cmd(MODE_REF, {64{1'b1}});
        queue_cmd(MODE_REF, pack_text("AZ"));
        queue_cmd(MODE_REF, pack_text("@[`{"));
        queue_cmd(MODE_REF, 64'h5A_0041);
        queue_cmd(MODE_REF, pack_text("AZ"));
        queue_cmd(MODE_SRC, 64'd0);
        queue_cmd(MODE_SRC, {64{1'b1}});
        queue_cmd(MODE_SRC, pack_text("aZ"));
        queue_cmd(MODE_SRC, pack_text("`{"));
        queue_cmd(MODE_SRC, 64'h7A_0061);
        queue_cmd(MODE_REPORT, 64'd0);
        queue_cmd(MODE_CLEAR, {64{1'b1}});
        queue_cmd(MODE_REPORT, 64'd0);
        queue_cmd(MODE_SRC, 64'd0);
        queue_cmd(MODE_CLEAR, 64'd0);
        queue_cmd(MODE_REF, pack_text("Word"));
        queue_cmd(MODE_SRC, pack_text("WORD"));
        queue_cmd(MODE_REPORT, 64'd0);

        // fill the store to the top, then overflow it and search it end to end
        queue_cmd(MODE_CLEAR, 64'd0);
        for (int i = 0; i < REF_WORDS; i++)
        begin
            w = ($urandom_range(0, 3) == 0) ? {$urandom, $urandom} : random_text();
            refs_now.push_back(w);
            queue_cmd(MODE_REF, w);
        end
        for (int i = 0; i < 3; i++)
            queue_cmd(MODE_REF, random_text());
        queue_cmd(MODE_SRC, recase(refs_now[0]));
        queue_cmd(MODE_SRC, recase(refs_now[REF_WORDS-1]));
        queue_cmd(MODE_SRC, recase(refs_now[$urandom_range(1, REF_WORDS-2)]));
        queue_cmd(MODE_SRC, {$urandom, $urandom});
        queue_cmd(MODE_REPORT, 64'd0);
        queue_cmd(MODE_CLEAR, 64'd0);

        // random: mostly store/check/report sequences, some raw noise
        queued = 0;
        while (queued < 450)
        begin
            if ($urandom_range(0, 9) == 0)
            begin
                queue_cmd(mode_t'($urandom_range(0, 3)), {$urandom, $urandom});
                queued++;
            end
            else
            begin
                refs_now.delete();
                if ($urandom_range(0, 4) != 0)
                begin
                    queue_cmd(MODE_CLEAR, {$urandom, $urandom});
                    queued++;
                end
                nref = $urandom_range(0, 24);
                for (int i = 0; i < nref; i++)
                begin
                    w = random_text();
                    refs_now.push_back(w);
                    queue_cmd(MODE_REF, w);
                end
                nsrc = $urandom_range(1, 16);
                for (int i = 0; i < nsrc; i++)
                begin
                    if (refs_now.size() > 0 && $urandom_range(0, 9) < 7)
                        w = recase(refs_now[$urandom_range(0, refs_now.size() - 1)]);
                    else
                        w = random_text();
                    queue_cmd(MODE_SRC, w);
                    if ($urandom_range(0, 4) == 0)
                    begin
                        queue_cmd(MODE_REPORT, {$urandom, $urandom});
                        queued++;
                    end
                end
                queue_cmd(MODE_REPORT, 64'd0);
                queued += nref + nsrc + 1;
            end
        end

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        while (word_cmds.size() != 0 || due_results.size() != 0)
            @(negedge clk);
        // a full-store search is the slowest command
        repeat (300) @(posedge clk);
        if (mismatches == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

    initial
    begin
        #4_000_000;
        $display("[FAIL] regression broken");
        $finish;
    end

endmodule

### filelist.f
design/wovc_pkg.sv
design/wovc_cell.sv
design/wovc_div.sv
design/word_overlap_counter_top.sv
tb/sv/word_overlap_counter_top_tb.sv
